// ===== hdl/dtws_pkg.sv =====
// Shared types and constants for the digit tube WS2812 frame encoder.
// No dependencies; used by dtws_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dtws_pkg;

	localparam int BITS_PER_LED = 24;

	// Operation codes carried in tuser
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_ONE_HIGH   = 3'd0;
	localparam logic [2:0] REG_ONE_LOW    = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
	localparam logic [2:0] REG_ZERO_LOW   = 3'd3;
	localparam logic [2:0] REG_LED_OFFSET = 3'd4;

	// Register values after reset
	localparam logic [7:0] RST_ONE_HIGH   = 8'd8;
	localparam logic [7:0] RST_ONE_LOW    = 8'd4;
	localparam logic [7:0] RST_ZERO_HIGH  = 8'd4;
	localparam logic [7:0] RST_ZERO_LOW   = 8'd8;
	localparam logic [5:0] RST_LED_OFFSET = 6'd10;

	typedef struct packed {
		logic [7:0] one_high_ticks;
		logic [7:0] one_low_ticks;
		logic [7:0] zero_high_ticks;
		logic [7:0] zero_low_ticks;
		logic [5:0] second_led_offset;
	} cfg_t;

	typedef struct packed {
		logic        operation;
		logic [2:0]  tube;
		logic [5:0]  digit;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} item_t;

	typedef struct packed {
		logic [5:0] line_levels;
		logic       busy_res;
		logic       frame_done;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic        sending;
		logic [2:0]  active_tube;
		logic [5:0]  lit_index;
		logic [23:0] grb_word;     // green 23..16, red 15..8, blue 7..0
		logic [5:0]  led_position;
		logic [4:0]  bit_position;
		logic        in_low_phase;
		logic [7:0]  phase_ticks;
	} enc_state_t;

endpackage

`default_nettype wire

// ===== hdl/dtws_step.sv =====
// Next-state and result logic for one beat of the frame encoder.
// Uses dtws_pkg types; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module dtws_step #(
	parameter int LEDS_PER_TUBE = 20,
	parameter int TUBE_COUNT    = 6
) (
	input  wire dtws_pkg::cfg_t       cfg,
	input  wire dtws_pkg::enc_state_t cur,
	input  wire dtws_pkg::item_t      item,
	output dtws_pkg::enc_state_t      nxt,
	output dtws_pkg::result_t         res
);

	localparam logic [6:0] LedEnd   = 7'(LEDS_PER_TUBE);
	localparam logic [2:0] TubeLast = 3'(TUBE_COUNT);
	localparam logic [4:0] BitLast  = 5'(dtws_pkg::BITS_PER_LED - 1);

	function automatic logic [5:0] tube_mask(input logic [2:0] t);
		logic [5:0] m;
		m = '0;
		if (t != 3'd0 && t <= TubeLast) begin
			m = 6'b1 << (t - 3'd1);
		end
		return m;
	endfunction

	logic       lit;
	logic       bit_one;
	logic [7:0] dur;
	logic [7:0] dur_eff;
	logic [7:0] ticks_inc;
	logic       tube_ok;

	always_comb begin
		lit = (cur.led_position == cur.lit_index) ||
			({1'b0, cur.led_position} ==
			 ({1'b0, cur.lit_index} + {1'b0, cfg.second_led_offset}));
		bit_one = lit && cur.grb_word[BitLast - cur.bit_position];
		if (!cur.in_low_phase) begin
			dur = bit_one ? cfg.one_high_ticks : cfg.zero_high_ticks;
		end else begin
			dur = bit_one ? cfg.one_low_ticks : cfg.zero_low_ticks;
		end
		dur_eff   = (dur == 8'd0) ? 8'd1 : dur;
		ticks_inc = cur.phase_ticks + 8'd1;
		tube_ok   = item.tube != 3'd0 && item.tube <= TubeLast;

		nxt = cur;
		res = '0;

		if (item.operation == dtws_pkg::OP_START) begin
			if (cur.sending || !tube_ok) begin
				res.rejected = 1'b1;
			end else begin
				nxt.sending      = 1'b1;
				nxt.active_tube  = item.tube;
				nxt.lit_index    = item.digit;
				nxt.grb_word     = {item.green, item.red, item.blue};
				nxt.led_position = '0;
				nxt.bit_position = '0;
				nxt.in_low_phase = 1'b0;
				nxt.phase_ticks  = '0;
			end
			// show the level the line holds now
			if (nxt.sending && !nxt.in_low_phase) begin
				res.line_levels = tube_mask(nxt.active_tube);
			end
		end else if (cur.sending) begin
			if (!cur.in_low_phase) begin
				res.line_levels = tube_mask(cur.active_tube);
			end
			nxt.phase_ticks = ticks_inc;
			if (ticks_inc >= dur_eff) begin
				nxt.phase_ticks = '0;
				if (!cur.in_low_phase) begin
					nxt.in_low_phase = 1'b1;
				end else begin
					nxt.in_low_phase = 1'b0;
					nxt.bit_position = cur.bit_position + 5'd1;
					if (cur.bit_position == BitLast) begin
						nxt.bit_position = '0;
						nxt.led_position = cur.led_position + 6'd1;
						// last bit of last LED: close the frame
						if ({1'b0, cur.led_position} + 7'd1 >= LedEnd) begin
							nxt.led_position = '0;
							nxt.sending      = 1'b0;
							res.frame_done   = 1'b1;
						end
					end
				end
			end
		end

		res.busy_res = nxt.sending;
	end

endmodule

`default_nettype wire

// ===== hdl/digit_tube_ws2812_frame_encoder.sv =====
// Top level of the digit tube WS2812 frame encoder: stream ports, registers.
// Depends on dtws_pkg and dtws_step.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is either a start (tuser high) that latches tube, digit and
// color, or one line tick that advances the WS2812 bit timing of the active
// chain by one step. Every beat yields exactly one output beat with the six
// data line levels, busy and rejected flags; tlast marks the final tick of a
// frame. One beat is taken per clock cycle while the output is not stalled; a
// beat passes an input register and then a result register, and its result is
// presented on the output from the result register. The encoder state updates
// once per beat in the step logic between them.
module digit_tube_ws2812_frame_encoder #(
	parameter int LEDS_PER_TUBE = 20,
	parameter int TUBE_COUNT    = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration write port
	input  wire        cfg_we,
	input  wire [2:0]  cfg_addr,
	input  wire [7:0]  cfg_wdata,
	// input stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [39:0] s_tdata,   // tube[2:0], digit[8:3], red[16:9], green[24:17],
	                              // blue[32:25], zero fill [39:33]
	input  wire        s_tuser,   // operation: 0 tick, 1 start
	// output stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // line_levels[5:0], busy_res[6], rejected[7]
	output logic       m_tlast    // frame_done
);

	dtws_pkg::cfg_t       cfg_q;
	dtws_pkg::enc_state_t state_q;
	dtws_pkg::enc_state_t state_nxt;
	dtws_pkg::item_t      item_s1;
	dtws_pkg::result_t    res_nxt;
	dtws_pkg::result_t    res_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_high_ticks    <= dtws_pkg::RST_ONE_HIGH;
			cfg_q.one_low_ticks     <= dtws_pkg::RST_ONE_LOW;
			cfg_q.zero_high_ticks   <= dtws_pkg::RST_ZERO_HIGH;
			cfg_q.zero_low_ticks    <= dtws_pkg::RST_ZERO_LOW;
			cfg_q.second_led_offset <= dtws_pkg::RST_LED_OFFSET;
		end else if (cfg_we) begin
			case (cfg_addr)
				dtws_pkg::REG_ONE_HIGH:   cfg_q.one_high_ticks    <= cfg_wdata;
				dtws_pkg::REG_ONE_LOW:    cfg_q.one_low_ticks     <= cfg_wdata;
				dtws_pkg::REG_ZERO_HIGH:  cfg_q.zero_high_ticks   <= cfg_wdata;
				dtws_pkg::REG_ZERO_LOW:   cfg_q.zero_low_ticks    <= cfg_wdata;
				dtws_pkg::REG_LED_OFFSET: cfg_q.second_led_offset <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// input register: hold the beat until the result register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation <= s_tuser;
			item_s1.tube      <= s_tdata[2:0];
			item_s1.digit     <= s_tdata[8:3];
			item_s1.red       <= s_tdata[16:9];
			item_s1.green     <= s_tdata[24:17];
			item_s1.blue      <= s_tdata[32:25];
		end
	end

	dtws_step #(
		.LEDS_PER_TUBE(LEDS_PER_TUBE),
		.TUBE_COUNT   (TUBE_COUNT)
	) u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.item(item_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.rejected, res_s2.busy_res, res_s2.line_levels};
	assign m_tlast  = res_s2.frame_done;

endmodule

`default_nettype wire

// ===== bench/dtws_frame_checker.sv =====
// Line-level checker for the digit tube WS2812 frame encoder: predicts every output
// beat from the accepted input beats and register writes, and compares it field by field.
// Depends on dtws_pkg for item, result, state and register types.
`timescale 1ns / 1ps

module dtws_frame_checker #(
	parameter int LEDS_PER_TUBE = 20,
	parameter int TUBE_COUNT    = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_addr,
	input  wire [7:0]  cfg_wdata,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [39:0] s_tdata,   // tube[2:0], digit[8:3], red[16:9], green[24:17],
	                              // blue[32:25], zero fill [39:33]
	input  wire        s_tuser,   // operation
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [7:0]  m_tdata,   // line_levels[5:0], busy_res[6], rejected[7]
	input  wire        m_tlast,   // frame_done
	output int         errors,
	output int         outstanding,
	output int         frames,
	output int         refusals
);
	import dtws_pkg::*;

	cfg_t       regs;
	enc_state_t enc;
	result_t    predicted_levels[$];

	function automatic logic bit_is_one();
		int   far_led;
		int   idx;
		logic lit;
		// second LED index is not wrapped, so it can lie past the chain
		far_led = int'(enc.lit_index) + int'(regs.second_led_offset);
		lit = (int'(enc.led_position) == int'(enc.lit_index)) ||
		      (int'(enc.led_position) == far_led);
		idx = BITS_PER_LED - 1 - int'(enc.bit_position);
		return lit && enc.grb_word[idx];
	endfunction

	function automatic logic [5:0] drive_mask();
		if (enc.active_tube == 3'd0 || enc.active_tube > TUBE_COUNT)
			return 6'd0;
		return 6'd1 << (enc.active_tube - 3'd1);
	endfunction

	function automatic result_t step_encoder(input item_t it);
		result_t    r;
		logic       one;
		logic [7:0] span;
		r = '0;
		if (it.operation == OP_START) begin
			if (enc.sending || it.tube == 3'd0 || it.tube > TUBE_COUNT) begin
				r.rejected = 1'b1;
			end else begin
				enc.sending      = 1'b1;
				enc.active_tube  = it.tube;
				enc.lit_index    = it.digit;
				enc.grb_word     = {it.green, it.red, it.blue};
				enc.led_position = '0;
				enc.bit_position = '0;
				enc.in_low_phase = 1'b0;
				enc.phase_ticks  = '0;
			end
			// show the level the line holds right now
			if (enc.sending && !enc.in_low_phase)
				r.line_levels = drive_mask();
		end else if (enc.sending) begin
			one = bit_is_one();
			if (!enc.in_low_phase) begin
				r.line_levels = drive_mask();
				span = one ? regs.one_high_ticks : regs.zero_high_ticks;
			end else begin
				span = one ? regs.one_low_ticks : regs.zero_low_ticks;
			end
			if (span == 8'd0)
				span = 8'd1;
			enc.phase_ticks = enc.phase_ticks + 8'd1;
			if (enc.phase_ticks >= span) begin
				enc.phase_ticks = '0;
				if (!enc.in_low_phase) begin
					enc.in_low_phase = 1'b1;
				end else begin
					enc.in_low_phase = 1'b0;
					if (enc.bit_position == BITS_PER_LED - 1) begin
						enc.bit_position = '0;
						if (enc.led_position == LEDS_PER_TUBE - 1) begin
							enc.led_position = '0;
							enc.sending      = 1'b0;
							r.frame_done     = 1'b1;
						end else begin
							enc.led_position = enc.led_position + 6'd1;
						end
					end else begin
						enc.bit_position = enc.bit_position + 5'd1;
					end
				end
			end
		end
		r.busy_res = enc.sending;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   it;
		result_t want;
		if (!arst_n) begin
			regs.one_high_ticks    = RST_ONE_HIGH;
			regs.one_low_ticks     = RST_ONE_LOW;
			regs.zero_high_ticks   = RST_ZERO_HIGH;
			regs.zero_low_ticks    = RST_ZERO_LOW;
			regs.second_led_offset = RST_LED_OFFSET;
			enc = '0;
			predicted_levels.delete();
			outstanding = 0;
			errors      = 0;
			frames      = 0;
			refusals    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ONE_HIGH:   regs.one_high_ticks    = cfg_wdata;
					REG_ONE_LOW:    regs.one_low_ticks     = cfg_wdata;
					REG_ZERO_HIGH:  regs.zero_high_ticks   = cfg_wdata;
					REG_ZERO_LOW:   regs.zero_low_ticks    = cfg_wdata;
					REG_LED_OFFSET: regs.second_led_offset = cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it.operation = s_tuser;
				it.tube      = s_tdata[2:0];
				it.digit     = s_tdata[8:3];
				it.red       = s_tdata[16:9];
				it.green     = s_tdata[24:17];
				it.blue      = s_tdata[32:25];
				predicted_levels.push_back(step_encoder(it));
			end
			if (m_tvalid && m_tready) begin
				if (predicted_levels.size() == 0) begin
					$error("output beat with no prediction: tdata %h tlast %b",
						m_tdata, m_tlast);
					errors++;
				end else begin
					want = predicted_levels.pop_front();
					if (m_tdata[5:0] !== want.line_levels) begin
						$error("line_levels: expected %h, got %h",
							want.line_levels, m_tdata[5:0]);
						errors++;
					end
					if (m_tdata[6] !== want.busy_res) begin
						$error("busy_res: expected %b, got %b", want.busy_res, m_tdata[6]);
						errors++;
					end
					if (m_tlast !== want.frame_done) begin
						$error("frame_done: expected %b, got %b", want.frame_done, m_tlast);
						errors++;
					end
					if (m_tdata[7] !== want.rejected) begin
						$error("rejected: expected %b, got %b", want.rejected, m_tdata[7]);
						errors++;
					end
					if (want.frame_done)
						frames++;
					if (want.rejected)
						refusals++;
				end
			end
			outstanding = predicted_levels.size();
		end
	end

endmodule

// ===== bench/digit_tube_ws2812_frame_encoder_tb.sv =====
// Testbench top for the digit tube WS2812 frame encoder: drives start and tick beats
// through several register settings with random stalls, and reports the verdict.
// Depends on dtws_pkg, the encoder RTL and dtws_frame_checker.
`timescale 1ns / 1ps

module digit_tube_ws2812_frame_encoder_tb;
	import dtws_pkg::*;

	localparam int LEDS_PER_TUBE = 20;
	localparam int TUBE_COUNT    = 6;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // tube[2:0], digit[8:3], red[16:9], green[24:17],
	                        // blue[32:25], zero fill [39:33]
	logic        s_tuser;   // operation: 0 tick, 1 start
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // line_levels[5:0], busy_res[6], rejected[7]
	logic        m_tlast;   // frame_done

	int errors;
	int outstanding;
	int frames;
	int refusals;
	int cycles   = 0;
	int beats    = 0;
	int starts   = 0;
	int settings = 1;
	bit gap_en   = 1'b1;
	bit stall_en = 1'b1;

	digit_tube_ws2812_frame_encoder #(
		.LEDS_PER_TUBE(LEDS_PER_TUBE),
		.TUBE_COUNT   (TUBE_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	dtws_frame_checker #(
		.LEDS_PER_TUBE(LEDS_PER_TUBE),
		.TUBE_COUNT   (TUBE_COUNT)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.outstanding(outstanding),
		.frames     (frames),
		.refusals   (refusals)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	always begin
		@(negedge clk);
		if (stall_en && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	function automatic item_t tick_item();
		item_t it;
		it = '0;
		it.operation = OP_TICK;
		return it;
	endfunction

	function automatic item_t start_item(input logic [2:0] tube, input logic [5:0] digit,
		input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		item_t it;
		it.operation = OP_START;
		it.tube      = tube;
		it.digit     = digit;
		it.red       = red;
		it.green     = green;
		it.blue      = blue;
		return it;
	endfunction

	// mostly ticks with junk payload; starts now and then, some with bad tubes
	function automatic item_t random_item(input int start_odds);
		item_t it;
		int    pick;
		it.operation = ($urandom_range(0, start_odds - 1) == 0) ? OP_START : OP_TICK;
		pick = $urandom_range(0, 9);
		it.tube = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 :
			3'($urandom_range(1, TUBE_COUNT));
		it.digit = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
			6'($urandom_range(0, LEDS_PER_TUBE - 1));
		it.red   = 8'($urandom);
		it.green = 8'($urandom);
		it.blue  = 8'($urandom);
		return it;
	endfunction

	task automatic push_beat(input item_t it);
		if (gap_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, it.blue, it.green, it.red, it.digit, it.tube};
		s_tuser  <= it.operation;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		beats++;
		if (it.operation == OP_START)
			starts++;
	endtask

	task automatic run_random(input int count, input int start_odds);
		repeat (count) push_beat(random_item(start_odds));
	endtask

	// drain in-flight beats, then rewrite every register plus one unused index
	task automatic apply_cfg(input cfg_t c, input logic [1:0] offset_pad);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_ONE_HIGH;
		cfg_wdata <= c.one_high_ticks;
		@(negedge clk);
		cfg_addr  <= REG_ONE_LOW;
		cfg_wdata <= c.one_low_ticks;
		@(negedge clk);
		cfg_addr  <= REG_ZERO_HIGH;
		cfg_wdata <= c.zero_high_ticks;
		@(negedge clk);
		cfg_addr  <= REG_ZERO_LOW;
		cfg_wdata <= c.zero_low_ticks;
		@(negedge clk);
		cfg_addr  <= REG_LED_OFFSET;
		cfg_wdata <= {offset_pad, c.second_led_offset};
		@(negedge clk);
		cfg_addr  <= 3'(REG_LED_OFFSET + 1 + $urandom_range(0, 2));
		cfg_wdata <= 8'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin : stimulus
		cfg_t mix;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_TICK;
		m_tready  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle tick, bad tubes, a real start, a start while busy
		push_beat(tick_item());
		push_beat(start_item(3'd0, 6'd0, 8'hFF, 8'hFF, 8'hFF));
		push_beat(start_item(3'd7, 6'd63, 8'hFF, 8'hFF, 8'hFF));
		push_beat(start_item(3'd3, 6'd0, 8'h00, 8'hFF, 8'hA5));
		push_beat(start_item(3'd1, 6'd1, 8'h12, 8'h34, 8'h56));
		repeat (14) push_beat(tick_item());
		push_beat(start_item(3'd6, 6'd63, 8'h00, 8'h00, 8'h00));
		repeat (5) push_beat(tick_item());

		// short bit times, zero-length phases; long enough for the running frame to end
		apply_cfg('{8'd2, 8'd0, 8'd0, 8'd1, 6'd5}, 2'b11);
		run_random(990, 250);

		// extreme durations and offset
		apply_cfg('{8'd255, 8'd1, 8'd0, 8'd255, 6'd63}, 2'b00);
		run_random(20, 8);

		mix.one_high_ticks    = 8'($urandom_range(0, 6));
		mix.one_low_ticks     = 8'($urandom_range(0, 6));
		mix.zero_high_ticks   = 8'($urandom_range(0, 6));
		mix.zero_low_ticks    = 8'($urandom_range(0, 6));
		mix.second_led_offset = 6'($urandom_range(0, 63));
		apply_cfg(mix, 2'($urandom_range(0, 3)));
		run_random(20, 8);
		// full rate to the end
		gap_en   <= 1'b0;
		stall_en <= 1'b0;
		run_random(20, 8);

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("Sent %0d beats (%0d starts) across %0d register settings.",
			beats, starts, settings);
		$display("Saw %0d complete frames and %0d refused starts.", frames, refusals);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dtws_pkg.sv
hdl/dtws_step.sv
hdl/digit_tube_ws2812_frame_encoder.sv
bench/dtws_frame_checker.sv
bench/digit_tube_ws2812_frame_encoder_tb.sv
